/* sv/csc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the complex sequence convolver.
// Used by csc_ctrl, csc_datapath and complex_sequence_convolver_top; no dependencies.
package csc_pkg;

  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_W       = 38;
  localparam int OUT_IDX_W   = 6;
  localparam int REQ_W       = 2;
  localparam int IN_DATA_W   = 2 * IN_SAMPLE_W;
  localparam int OUT_DATA_W  = 88;

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic rd_en;
    logic acc_clr;
    logic out_load;
    logic out_empty;
    logic out_last;
  } csc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } csc_sts_t;

endpackage

/* sv/csc_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the complex sequence convolver: sample memories, complex multiply
// pipeline, accumulator and output word register. Depends on csc_pkg.
module csc_datapath #(
  parameter int MAX_LEN      = 32,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ADDR_W       = 5,
  parameter int K_W          = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csc_pkg::csc_cmd_t                   cmd_i,
  output csc_pkg::csc_sts_t                   sts_o,
  input  logic [ADDR_W-1:0]                   wr_addr_i,
  input  logic [ADDR_W-1:0]                   rd_addr_a_i,
  input  logic [ADDR_W-1:0]                   rd_addr_b_i,
  input  logic [K_W-1:0]                      k_i,
  input  logic [csc_pkg::IN_SAMPLE_W-1:0]     sample_real_i,
  input  logic [csc_pkg::IN_SAMPLE_W-1:0]     sample_imag_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic signed [csc_pkg::OUT_W-1:0]    out_real_o,
  output logic signed [csc_pkg::OUT_W-1:0]    out_imag_o,
  output logic [csc_pkg::OUT_IDX_W-1:0]       out_index_o,
  output logic                                out_last_o,
  output logic                                out_empty_o
);
  import csc_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int TAKE_W = (SW < IN_SAMPLE_W) ? SW : IN_SAMPLE_W;
  localparam int PROD_W = 2 * SW;
  localparam int PART_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 7;
  localparam int SAT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam int K_EXT_W = (K_W > OUT_IDX_W) ? K_W : OUT_IDX_W;

  logic [2*SW-1:0] mem_first  [MAX_LEN];
  logic [2*SW-1:0] mem_second [MAX_LEN];

  logic [SW-1:0] wr_real, wr_imag;
  logic [2*SW-1:0] rd_a_q, rd_b_q;
  logic va_q, vb_q, vc_q;
  logic signed [PROD_W-1:0] p_ac_q, p_bd_q, p_ad_q, p_bc_q;
  logic signed [PART_W-1:0] part_re_q, part_im_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [SW-1:0] a_s, b_s, c_s, d_s;
  logic signed [SAT_W-1:0] ext_re, ext_im;
  logic signed [OUT_W-1:0] sat_re, sat_im;
  logic out_valid_q;
  logic signed [OUT_W-1:0] out_real_q, out_imag_q;
  logic [OUT_IDX_W-1:0] out_index_q;
  logic out_last_q, out_empty_q;

  assign wr_real = SW'(sample_real_i[TAKE_W-1:0]);
  assign wr_imag = SW'(sample_imag_i[TAKE_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_first) begin
      mem_first[wr_addr_i] <= {wr_imag, wr_real};
    end
    if (cmd_i.wr_second) begin
      mem_second[wr_addr_i] <= {wr_imag, wr_real};
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_first[rd_addr_a_i];
      rd_b_q <= mem_second[rd_addr_b_i];
    end
  end

  assign a_s = signed'(rd_a_q[SW-1:0]);
  assign b_s = signed'(rd_a_q[2*SW-1:SW]);
  assign c_s = signed'(rd_b_q[SW-1:0]);
  assign d_s = signed'(rd_b_q[2*SW-1:SW]);

  always_ff @(posedge clk_i) begin
    p_ac_q    <= a_s * c_s;
    p_bd_q    <= b_s * d_s;
    p_ad_q    <= a_s * d_s;
    p_bc_q    <= b_s * c_s;
    part_re_q <= PART_W'(p_ac_q) - PART_W'(p_bd_q);
    part_im_q <= PART_W'(p_ad_q) + PART_W'(p_bc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= cmd_i.rd_en;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (vc_q) begin
      acc_re_q <= acc_re_q + ACC_W'(part_re_q);
      acc_im_q <= acc_im_q + ACC_W'(part_im_q);
    end
  end

  assign ext_re = SAT_W'(acc_re_q);
  assign ext_im = SAT_W'(acc_im_q);

  always_comb begin
    if ((&ext_re[SAT_W-1:OUT_W-1]) || !(|ext_re[SAT_W-1:OUT_W-1])) begin
      sat_re = ext_re[OUT_W-1:0];
    end else begin
      sat_re = ext_re[SAT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    if ((&ext_im[SAT_W-1:OUT_W-1]) || !(|ext_im[SAT_W-1:OUT_W-1])) begin
      sat_im = ext_im[OUT_W-1:0];
    end else begin
      sat_im = ext_im[SAT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q  <= cmd_i.out_last;
      out_empty_q <= cmd_i.out_empty;
      if (cmd_i.out_empty) begin
        out_real_q  <= '0;
        out_imag_q  <= '0;
        out_index_q <= '0;
      end else begin
        out_real_q  <= sat_re;
        out_imag_q  <= sat_im;
        out_index_q <= OUT_IDX_W'(K_EXT_W'(k_i));
      end
    end
  end

  assign sts_o.pipe_busy = va_q | vb_q | vc_q;
  assign sts_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o  = out_valid_q;
  assign out_real_o  = out_real_q;
  assign out_imag_o  = out_imag_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule

/* sv/csc_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the complex sequence convolver: sequence lengths, request decode
// and the walk over output and product indices. Depends on csc_pkg.
module csc_ctrl #(
  parameter int MAX_LEN = 32,
  parameter int ADDR_W  = 5,
  parameter int LEN_W   = 6,
  parameter int K_W     = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [csc_pkg::REQ_W-1:0] req_type_i,
  output csc_pkg::csc_cmd_t         cmd_o,
  input  csc_pkg::csc_sts_t         sts_i,
  output logic [ADDR_W-1:0]         wr_addr_o,
  output logic [ADDR_W-1:0]         rd_addr_a_o,
  output logic [ADDR_W-1:0]         rd_addr_b_o,
  output logic [K_W-1:0]            k_o
);
  import csc_pkg::*;

  localparam int CMP_W = LEN_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  logic [2:0] state_q, state_d;
  logic [LEN_W-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [K_W-1:0] k_q, k_d;
  logic [ADDR_W-1:0] i_q, i_d, i_hi_q, i_hi_d;
  logic accept;
  logic [CMP_W-1:0] k_ext, k_last, l1_ext, l2_ext, i_lo_w, i_hi_w, j_w;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);
  assign k_ext  = CMP_W'(k_q);
  assign l1_ext = CMP_W'(len1_q);
  assign l2_ext = CMP_W'(len2_q);
  assign k_last = l1_ext + l2_ext - CMP_W'(2);
  assign i_lo_w = (k_ext + CMP_W'(1) > l2_ext) ? (k_ext + CMP_W'(1) - l2_ext) : '0;
  assign i_hi_w = (k_ext < l1_ext - CMP_W'(1)) ? k_ext : (l1_ext - CMP_W'(1));
  assign j_w    = k_ext - CMP_W'(i_q);

  always_comb begin
    state_d = state_q;
    len1_d  = len1_q;
    len2_d  = len2_q;
    k_d     = k_q;
    i_d     = i_q;
    i_hi_d  = i_hi_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_FIRST: begin
              if (len1_q < LEN_W'(MAX_LEN)) begin
                cmd_o.wr_first = 1'b1;
                len1_d = len1_q + LEN_W'(1);
              end
            end
            REQ_SECOND: begin
              if (len2_q < LEN_W'(MAX_LEN)) begin
                cmd_o.wr_second = 1'b1;
                len2_d = len2_q + LEN_W'(1);
              end
            end
            REQ_START: begin
              if (len1_q == '0 || len2_q == '0) begin
                state_d = ST_EMPTY;
              end else begin
                k_d     = '0;
                state_d = ST_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.acc_clr = 1'b1;
        i_d     = i_lo_w[ADDR_W-1:0];
        i_hi_d  = i_hi_w[ADDR_W-1:0];
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.rd_en = 1'b1;
        if (i_q == i_hi_q) begin
          state_d = ST_FLUSH;
        end else begin
          i_d = i_q + ADDR_W'(1);
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pipe_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (k_ext == k_last) begin
            cmd_o.out_last = 1'b1;
            len1_d  = '0;
            len2_d  = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + K_W'(1);
            state_d = ST_SETUP;
          end
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = 1'b1;
          cmd_o.out_last  = 1'b1;
          len1_d  = '0;
          len2_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len1_q  <= '0;
      len2_q  <= '0;
      k_q     <= '0;
      i_q     <= '0;
      i_hi_q  <= '0;
    end else begin
      state_q <= state_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      k_q     <= k_d;
      i_q     <= i_d;
      i_hi_q  <= i_hi_d;
    end
  end

  assign s_tready_o  = (state_q == ST_IDLE);
  assign wr_addr_o   = (req_type_i == REQ_FIRST) ? len1_q[ADDR_W-1:0] : len2_q[ADDR_W-1:0];
  assign rd_addr_a_o = i_q;
  assign rd_addr_b_o = j_w[ADDR_W-1:0];
  assign k_o         = k_q;

endmodule

/* sv/complex_sequence_convolver_top.sv */
`timescale 1ns / 1ps
// Top level of the complex sequence convolver: stream ports, controller and datapath.
// Depends on csc_pkg, csc_ctrl and csc_datapath.
//
// Load words (tuser 0 or 1) append one complex sample to the first or second
// sequence and are taken one per cycle; loads beyond MAX_LEN are dropped. A start
// word (tuser 2) produces the full linear convolution, indices 0 to L1+L2-2, one
// output word per index with tlast on the final one, then empties both sequences.
// If either sequence is empty, a single word with the empty flag and tlast is sent.
// Each output index k sums its overlap(k) product terms: one memory read pair per cycle
// feeds a single complex multiply-accumulate pipeline that is drained before each
// word is presented.
// No new word is accepted until the last output word of a run is registered.
module complex_sequence_convolver_top #(
  parameter int MAX_LEN      = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: sample_real[15:0], sample_imag[31:16].
  input  logic [csc_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // Fields from bit 0: req_type[1:0].
  input  logic [csc_pkg::REQ_W-1:0]           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0: out_real[37:0], out_imag[75:38], out_index[81:76], zeros.
  output logic [csc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // Fields from bit 0: out_empty[0].
  output logic                                m_axis_tuser_o
);
  import csc_pkg::*;

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int K_W    = $clog2(2 * MAX_LEN);
  localparam int PAD_W  = OUT_DATA_W - 2 * OUT_W - OUT_IDX_W;

  csc_cmd_t cmd;
  csc_sts_t sts;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [K_W-1:0] k;
  logic signed [OUT_W-1:0] out_real, out_imag;
  logic [OUT_IDX_W-1:0] out_index;

  csc_ctrl #(
    .MAX_LEN (MAX_LEN),
    .ADDR_W  (ADDR_W),
    .LEN_W   (LEN_W),
    .K_W     (K_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .wr_addr_o   (wr_addr),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .k_o         (k)
  );

  csc_datapath #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ADDR_W       (ADDR_W),
    .K_W          (K_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .wr_addr_i     (wr_addr),
    .rd_addr_a_i   (rd_addr_a),
    .rd_addr_b_i   (rd_addr_b),
    .k_i           (k),
    .sample_real_i (s_axis_tdata_i[IN_SAMPLE_W-1:0]),
    .sample_imag_i (s_axis_tdata_i[IN_DATA_W-1:IN_SAMPLE_W]),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .out_real_o    (out_real),
    .out_imag_o    (out_imag),
    .out_index_o   (out_index),
    .out_last_o    (m_axis_tlast_o),
    .out_empty_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_index, out_imag, out_real};

endmodule

/* bench/complex_sequence_convolver_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for complex_sequence_convolver_top: directed and random load and
// start words with random idling on both streams, checked against an in-bench convolution.
// Depends on csc_pkg and the convolver RTL only.
module complex_sequence_convolver_top_test;
  import csc_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 220;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_LIMIT = 10;
  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic [OUT_IDX_W-1:0]    idx;
    logic                    last;
    logic                    empty;
  } conv_word_t;

  logic clk_i;
  logic rst_n;
  logic s_valid;
  logic [IN_DATA_W-1:0] s_data;
  logic [REQ_W-1:0] s_user;
  logic m_ready;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic m_axis_tuser_o;

  logic signed [SAMPLE_WIDTH-1:0] first_re [MAX_LEN];
  logic signed [SAMPLE_WIDTH-1:0] first_im [MAX_LEN];
  logic signed [SAMPLE_WIDTH-1:0] second_re [MAX_LEN];
  logic signed [SAMPLE_WIDTH-1:0] second_im [MAX_LEN];
  int first_len = 0;
  int second_len = 0;
  conv_word_t pending_words [$];

  int counted_words = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_calm = 0;
  int recv_calm = 0;
  bit hold_pending = 1'b0;

  complex_sequence_convolver_top #(
    .MAX_LEN(MAX_LEN),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tlast_o(m_axis_tlast_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** complex_sequence_convolver_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [OUT_W-1:0] clamp_sum(input longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // Updates the sequence stores for one accepted word and queues the words a start
  // produces. Returns 1 when the word has an effect.
  function automatic bit predict_word(input logic [REQ_W-1:0] req,
                                      input logic signed [SAMPLE_WIDTH-1:0] re,
                                      input logic signed [SAMPLE_WIDTH-1:0] im);
    conv_word_t w;
    longint acc_re, acc_im, a, b, c, d;
    int total, k, i;
    predict_word = 1'b0;
    if (req == REQ_FIRST && first_len < MAX_LEN) begin
      first_re[first_len] = re;
      first_im[first_len] = im;
      first_len++;
      predict_word = 1'b1;
    end else if (req == REQ_SECOND && second_len < MAX_LEN) begin
      second_re[second_len] = re;
      second_im[second_len] = im;
      second_len++;
      predict_word = 1'b1;
    end else if (req == REQ_START) begin
      predict_word = 1'b1;
      if (first_len == 0 || second_len == 0) begin
        w.re = '0;
        w.im = '0;
        w.idx = '0;
        w.last = 1'b1;
        w.empty = 1'b1;
        pending_words = {pending_words, w};
      end else begin
        total = first_len + second_len - 1;
        for (k = 0; k < total; k++) begin
          acc_re = 0;
          acc_im = 0;
          for (i = 0; i < first_len; i++) begin
            if (k - i >= 0 && k - i < second_len) begin
              a = first_re[i];
              b = first_im[i];
              c = second_re[k-i];
              d = second_im[k-i];
              acc_re += a * c - b * d;
              acc_im += a * d + b * c;
            end
          end
          w.re = clamp_sum(acc_re);
          w.im = clamp_sum(acc_im);
          w.idx = k[OUT_IDX_W-1:0];
          w.last = (k == total - 1);
          w.empty = 1'b0;
          pending_words = {pending_words, w};
        end
      end
      first_len = 0;
      second_len = 0;
    end
  endfunction

  // Draws a random idle gap, with occasional runs of back-to-back words.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [SAMPLE_WIDTH-1:0] re,
                           input logic [SAMPLE_WIDTH-1:0] im);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= req;
    s_data <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_word(req, re, im)) counted_words++;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic send_run(input int n_first, input int n_second);
    while (n_first > 0 || n_second > 0) begin
      if ($urandom_range(0, 24) == 0)
        send_word(REQ_UNUSED, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
      if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 0)) begin
        send_word(REQ_FIRST, rand_sample(), rand_sample());
        n_first--;
      end else begin
        send_word(REQ_SECOND, rand_sample(), rand_sample());
        n_second--;
      end
    end
    send_word(REQ_START, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
  endtask

  task automatic test_empty_sequences();
    send_word(REQ_START, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
    send_word(REQ_FIRST, 16'h7fff, 16'h8000);
    send_word(REQ_START, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
    send_word(REQ_SECOND, 16'hffff, 16'h0001);
    send_word(REQ_START, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
  endtask

  task automatic test_extreme_samples();
    send_word(REQ_FIRST, 16'h8000, 16'h8000);
    send_word(REQ_SECOND, 16'h8000, 16'h8000);
    send_word(REQ_START, 16'hffff, 16'hffff);
    send_word(REQ_FIRST, 16'h8000, 16'h8000);
    send_word(REQ_FIRST, 16'h7fff, 16'h7fff);
    send_word(REQ_UNUSED, 16'h1234, 16'hfedc);
    send_word(REQ_FIRST, 16'h0000, 16'hffff);
    send_word(REQ_SECOND, 16'h8000, 16'h7fff);
    send_word(REQ_SECOND, 16'h8000, 16'h8000);
    send_word(REQ_SECOND, 16'h7fff, 16'h8000);
    send_word(REQ_START, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_sequences();
    int i;
    // Largest magnitude: both sequences full of the most negative sample, plus overfill.
    for (i = 0; i < MAX_LEN + 2; i++) begin
      send_word(REQ_FIRST, 16'h8000, 16'h8000);
      send_word(REQ_SECOND, 16'h8000, 16'h8000);
    end
    send_word(REQ_START, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
    wait_idle();
    send_run(MAX_LEN + 1, 1);
    wait_idle();
    send_run(1, MAX_LEN);
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    send_run(10, 10);
    send_run(4, 3);
  endtask

  task automatic test_random_runs();
    int first_goal, n_first, n_second, pick;
    first_goal = counted_words;
    while (counted_words - first_goal < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        n_first = $urandom_range(1, 6);
        n_second = $urandom_range(1, 6);
      end else if (pick < 92) begin
        n_first = $urandom_range(1, 20);
        n_second = $urandom_range(1, 20);
      end else begin
        n_first = $urandom_range(26, MAX_LEN + 3);
        n_second = $urandom_range(1, MAX_LEN + 3);
      end
      if (pick % 10 == 0) n_first = 0;
      else if (pick % 10 == 1) n_second = 0;
      send_run(n_first, n_second);
    end
  endtask

  initial begin : receiver
    int gap;
    m_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : output_check
    conv_word_t want;
    logic signed [OUT_W-1:0] got_re, got_im;
    logic [OUT_IDX_W-1:0] got_idx;
    logic [OUT_DATA_W-1:OUT_IDX_W+2*OUT_W] got_pad;
    if (rst_n === 1'b1 && m_axis_tvalid_o && m_ready) begin
      got_re = m_axis_tdata_o[OUT_W-1:0];
      got_im = m_axis_tdata_o[2*OUT_W-1:OUT_W];
      got_idx = m_axis_tdata_o[2*OUT_W+OUT_IDX_W-1:2*OUT_W];
      got_pad = m_axis_tdata_o[OUT_DATA_W-1:2*OUT_W+OUT_IDX_W];
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected word re=%0d im=%0d idx=%0d last=%b empty=%b", $realtime,
                   got_re, got_im, got_idx, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = pending_words.pop_front();
        if (got_re !== want.re || got_im !== want.im || got_idx !== want.idx ||
            got_pad !== '0 || m_axis_tlast_o !== want.last ||
            m_axis_tuser_o !== want.empty) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"%0t: mismatch want re=%0d im=%0d idx=%0d last=%b empty=%b, ",
                      "got re=%0d im=%0d idx=%0d last=%b empty=%b pad=%h"},
                     $realtime, want.re, want.im, want.idx, want.last, want.empty,
                     got_re, got_im, got_idx, m_axis_tlast_o, m_axis_tuser_o, got_pad);
        end
      end
    end
  end

  initial begin
    s_valid <= 1'b0;
    s_user <= REQ_FIRST;
    s_data <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_sequences();
    wait_idle();
    test_extreme_samples();
    wait_idle();
    test_full_sequences();
    wait_idle();
    test_backpressure();
    wait_idle();
    test_random_runs();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("** complex_sequence_convolver_top: PASSED **");
    end else begin
      $display("** complex_sequence_convolver_top: FAILED **");
    end
    $finish;
  end

endmodule
